>>> design/bmd_pkg.sv
// Shared types and constants for the 3D binary mask dilation block.
package bmd_pkg;

  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;
  localparam int BAND_IN_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND   = 2'd3;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // take the input item
    logic rd_item;   // read the addressed row for a load
    logic wr_item;   // write back the modified row
    logic q_init;    // latch window edges and x mask, clear accumulator
    logic scan;      // read one window row and step the row counters
    logic out_load;  // move the result into the output register
  } bmd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;        // item coordinate outside the grid
    logic is_query;
    logic scan_last;  // current scan address is the last window row
    logic out_free;   // output register can take a result this cycle
  } bmd_status_t;

endpackage

>>> design/binary_mask_dilation_3d.sv
// Top level of the 3D binary mask dilation block: controller plus datapath.
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  input   | in_valid, in_stall, in_mode, in_load_bit, in_cell_* | in, in_stall out
//  result  | out_valid, out_stall, out_near_solid, out_bad_coordinate | out, out_stall in
//  config  | cfg_we, cfg_index, cfg_data                         | in
//
// A load reads the addressed row, then writes it back with the new bit at x.
// A query makes one row-memory read per window row, over the y window and the z
// window, masks each row by the x span and ORs the results into the accumulator.
// A coordinate outside the grid skips the row memory entirely. One item is in work at a time;
// the next is taken while the result register still waits for its transfer.
// Reset (synchronous, rst_n low) clears control and restores the config defaults;
// the row memory is not cleared. out_stall holds a result in the output register.
module binary_mask_dilation_3d #(
  parameter int MAX_SIZE = 64,
  parameter int MAX_BAND = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic                              in_load_bit,
  input  logic [bmd_pkg::COORD_W-1:0]       in_cell_x,
  input  logic [bmd_pkg::COORD_W-1:0]       in_cell_y,
  input  logic [bmd_pkg::COORD_W-1:0]       in_cell_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_near_solid,
  output logic                              out_bad_coordinate
);
  import bmd_pkg::*;

  bmd_cmd_t    cmd;
  bmd_status_t status;

  bmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bmd_datapath #(
    .MAX_SIZE (MAX_SIZE),
    .MAX_BAND (MAX_BAND)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_mode            (in_mode),
    .in_load_bit        (in_load_bit),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .in_cell_z          (in_cell_z),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_near_solid     (out_near_solid),
    .out_bad_coordinate (out_bad_coordinate)
  );

endmodule

>>> design/bmd_ctrl.sv
// Controller state machine sequencing loads, window scans and result hand-off.
module bmd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bmd_pkg::bmd_status_t status,
  output bmd_pkg::bmd_cmd_t    cmd
);
  import bmd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_LD_WR  = 3'd2;
  localparam logic [2:0] S_Q_SCAN = 3'd3;
  localparam logic [2:0] S_Q_TAIL = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (status.bad) begin
          state_nxt = S_DONE;
        end else if (status.is_query) begin
          cmd.q_init = 1'b1;
          state_nxt  = S_Q_SCAN;
        end else begin
          cmd.rd_item = 1'b1;
          state_nxt   = S_LD_WR;
        end
      end
      S_LD_WR: begin
        cmd.wr_item = 1'b1;
        state_nxt   = S_DONE;
      end
      S_Q_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) state_nxt = S_Q_TAIL;
      end
      S_Q_TAIL: begin
        // last row read lands in the accumulator this cycle
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/bmd_datapath.sv
// Datapath: config registers, item registers, row memory, window scan and result register.
module bmd_datapath #(
  parameter int MAX_SIZE = 64,
  parameter int MAX_BAND = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bmd_pkg::bmd_cmd_t                 cmd,
  output bmd_pkg::bmd_status_t              status,
  input  logic                              cfg_we,
  input  logic [bmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_mode,
  input  logic                              in_load_bit,
  input  logic [bmd_pkg::COORD_W-1:0]       in_cell_x,
  input  logic [bmd_pkg::COORD_W-1:0]       in_cell_y,
  input  logic [bmd_pkg::COORD_W-1:0]       in_cell_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_near_solid,
  output logic                              out_bad_coordinate
);
  import bmd_pkg::*;

  localparam int SZW   = $clog2(MAX_SIZE + 1);
  localparam int CW    = (SZW > CFG_W) ? SZW : CFG_W;
  localparam int BW    = (MAX_BAND > 0) ? $clog2(MAX_BAND + 1) : 1;
  localparam int AW1   = $clog2(MAX_SIZE);
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;

  function automatic logic [SZW-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CW-1:0] w;
    begin
      w = CW'(v);
      if (w == '0) return SZW'(1);
      else if (w > CW'(MAX_SIZE)) return SZW'(MAX_SIZE);
      else return SZW'(w);
    end
  endfunction

  function automatic logic [BW-1:0] clamp_band(input logic [BAND_IN_W-1:0] v);
    logic [CW-1:0] w;
    begin
      w = CW'(v);
      if (w > CW'(MAX_BAND)) return BW'(MAX_BAND);
      else return BW'(w);
    end
  endfunction

  // configuration
  logic [SZW-1:0] size_x_r, size_y_r, size_z_r;
  logic [BW-1:0]  band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= clamp_size(CFG_W'(64));
      size_y_r <= clamp_size(CFG_W'(64));
      size_z_r <= clamp_size(CFG_W'(64));
      band_r   <= clamp_band(BAND_IN_W'(1));
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r <= clamp_size(cfg_data);
        REG_SIZE_Y: size_y_r <= clamp_size(cfg_data);
        REG_SIZE_Z: size_z_r <= clamp_size(cfg_data);
        REG_BAND:   band_r   <= clamp_band(cfg_data[BAND_IN_W-1:0]);
        default: ;
      endcase
    end
  end

  // item registers
  logic               mode_r, load_bit_r;
  logic [COORD_W-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r     <= in_mode;
      load_bit_r <= in_load_bit;
      x_r        <= in_cell_x;
      y_r        <= in_cell_y;
      z_r        <= in_cell_z;
    end
  end

  logic [CW-1:0] xw, yw, zw, bw;
  logic          bad;

  assign xw = CW'(x_r);
  assign yw = CW'(y_r);
  assign zw = CW'(z_r);
  assign bw = CW'(band_r);
  assign bad = (xw >= CW'(size_x_r)) || (yw >= CW'(size_y_r)) || (zw >= CW'(size_z_r));

  // window edges, clipped at zero and at size - 1
  logic [CW-1:0] xh, yh, zh;
  logic [AW1-1:0] x0, x1, y0, y1, z0, z1;

  assign xh = xw + bw;
  assign yh = yw + bw;
  assign zh = zw + bw;

  always_comb begin
    x0 = (xw >= bw) ? AW1'(xw - bw) : '0;
    y0 = (yw >= bw) ? AW1'(yw - bw) : '0;
    z0 = (zw >= bw) ? AW1'(zw - bw) : '0;
    x1 = (xh >= CW'(size_x_r)) ? AW1'(CW'(size_x_r) - CW'(1)) : AW1'(xh);
    y1 = (yh >= CW'(size_y_r)) ? AW1'(CW'(size_y_r) - CW'(1)) : AW1'(yh);
    z1 = (zh >= CW'(size_z_r)) ? AW1'(CW'(size_z_r) - CW'(1)) : AW1'(zh);
  end

  // scan state
  logic [AW1-1:0]      y0_r, y1_r, z1_r, yc_r, zc_r;
  logic [MAX_SIZE-1:0] mask_r;
  logic                rd_vld_r;
  logic                acc_r;
  logic                scan_last;

  assign scan_last = (yc_r == y1_r) && (zc_r == z1_r);

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      y0_r   <= y0;
      y1_r   <= y1;
      z1_r   <= z1;
      yc_r   <= y0;
      zc_r   <= z0;
      mask_r <= ({MAX_SIZE{1'b1}} << x0) &
                ({MAX_SIZE{1'b1}} >> (AW1'(MAX_SIZE - 1) - x1));
    end else if (cmd.scan) begin
      if (yc_r == y1_r) begin
        yc_r <= y0_r;
        zc_r <= zc_r + AW1'(1);
      end else begin
        yc_r <= yc_r + AW1'(1);
      end
    end
  end

  // row memory, one MAX_SIZE-bit row per (y, z)
  logic [MAX_SIZE-1:0] rows_mem [DEPTH];
  logic [MAX_SIZE-1:0] rd_data_r;
  logic [2*AW1-1:0]    rd_addr, item_addr;
  logic [MAX_SIZE-1:0] wr_data;
  logic [AW1-1:0]      x_idx;

  assign item_addr = {AW1'(zw), AW1'(yw)};
  assign rd_addr   = cmd.scan ? {zc_r, yc_r} : item_addr;
  assign x_idx     = AW1'(xw);

  always_comb begin
    wr_data        = rd_data_r;
    wr_data[x_idx] = load_bit_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_item) rows_mem[item_addr] <= wr_data;
    if (cmd.rd_item || cmd.scan) rd_data_r <= rows_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      acc_r <= 1'b0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r | (|(rd_data_r & mask_r));
    end
  end

  // result register
  logic out_valid_r, out_near_r, out_bad_r;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_near_r <= (mode_r == MODE_QUERY) && !bad && acc_r;
      out_bad_r  <= bad;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_near_solid     = out_near_r;
  assign out_bad_coordinate = out_bad_r;

  assign status.bad       = bad;
  assign status.is_query  = (mode_r == MODE_QUERY);
  assign status.scan_last = scan_last;
  assign status.out_free  = out_free;

endmodule
